FILE: hdl/ssd_pkg.sv
// Shared constants for the segment-pair squared distance pipeline.
// No dependencies.
package ssd_pkg;
  localparam int COORD_BITS_DEF      = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int DIST_W              = 52;
  localparam int PARAM_W             = 17;
  localparam int CUT_FRAC            = 8;
  localparam int NUM_DOT             = 5;
  localparam int NUM_WPROD           = 6;
endpackage

FILE: hdl/ssd_if.sv
// Valid/ready channels for segment-pair words and distance result words.
// Depends on ssd_pkg.
interface ssd_in_if import ssd_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg0_start_x;
  logic signed [COORD_BITS-1:0] seg0_start_y;
  logic signed [COORD_BITS-1:0] seg0_start_z;
  logic signed [COORD_BITS-1:0] seg0_end_x;
  logic signed [COORD_BITS-1:0] seg0_end_y;
  logic signed [COORD_BITS-1:0] seg0_end_z;
  logic signed [COORD_BITS-1:0] seg1_start_x;
  logic signed [COORD_BITS-1:0] seg1_start_y;
  logic signed [COORD_BITS-1:0] seg1_start_z;
  logic signed [COORD_BITS-1:0] seg1_end_x;
  logic signed [COORD_BITS-1:0] seg1_end_y;
  logic signed [COORD_BITS-1:0] seg1_end_z;
  modport source (output valid, seg0_start_x, seg0_start_y, seg0_start_z,
                  seg0_end_x, seg0_end_y, seg0_end_z, seg1_start_x, seg1_start_y,
                  seg1_start_z, seg1_end_x, seg1_end_y, seg1_end_z, input ready);
  modport sink (input valid, seg0_start_x, seg0_start_y, seg0_start_z,
                seg0_end_x, seg0_end_y, seg0_end_z, seg1_start_x, seg1_start_y,
                seg1_start_z, seg1_end_x, seg1_end_y, seg1_end_z, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  dist_squared;
  logic [PARAM_W-1:0] s_param;
  logic [PARAM_W-1:0] t_param;
  modport source (output valid, dist_squared, s_param, t_param, input ready);
  modport sink (input valid, dist_squared, s_param, t_param, output ready);
endinterface

FILE: hdl/segment_segment_distance_sq.sv
// Closest points between two 3D segments: s, t and squared distance per word.
// Depends on ssd_pkg and ssd_if.
// Fully pipelined: one word per cycle when the output is not stalled.
// Depth is set by the restoring dividers for s and t, which retire one quotient bit per
// stage; every stage holds its word when the next is full and stalled.
module segment_segment_distance_sq import ssd_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ssd_in_if.sink    in_ch,
  ssd_out_if.source out_ch
);
  localparam int C   = COORD_BITS;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int P   = C + 1;
  localparam int PW  = 2 * P;
  localparam int DW  = PW + 2;
  localparam int H   = DW / 2;
  localparam int WW  = 2 * DW + 1;
  localparam int MPW = C + F + 3;
  localparam int VW  = C + F + 5;
  localparam int MW  = VW - (F - CUT_FRAC);

  localparam int S_IN  = 0;
  localparam int S_DIR = 1;
  localparam int S_PRD = 2;
  localparam int S_DOT = 3;
  localparam int S_PP  = 4;
  localparam int S_FP  = 5;
  localparam int S_DET = 6;
  localparam int S_CLP = 7;
  localparam int S_DIV = 8;
  localparam int S_SEL = S_DIV + F + 1;
  localparam int S_MUL = S_SEL + 1;
  localparam int S_VEC = S_MUL + 1;
  localparam int S_SQR = S_VEC + 1;
  localparam int S_OUT = S_SQR + 1;
  localparam int NS    = S_OUT + 1;

  localparam int MX [NUM_WPROD] = '{0, 1, 1, 2, 0, 1};
  localparam int MY [NUM_WPROD] = '{2, 1, 4, 3, 4, 3};

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  assign en[NS-1] = !vld_r[NS-1] || out_ch.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = en[S_IN];

  logic signed [C-1:0] p_r [12];
  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      p_r[0]  <= in_ch.seg0_start_x;
      p_r[1]  <= in_ch.seg0_start_y;
      p_r[2]  <= in_ch.seg0_start_z;
      p_r[3]  <= in_ch.seg0_end_x;
      p_r[4]  <= in_ch.seg0_end_y;
      p_r[5]  <= in_ch.seg0_end_z;
      p_r[6]  <= in_ch.seg1_start_x;
      p_r[7]  <= in_ch.seg1_start_y;
      p_r[8]  <= in_ch.seg1_start_z;
      p_r[9]  <= in_ch.seg1_end_x;
      p_r[10] <= in_ch.seg1_end_y;
      p_r[11] <= in_ch.seg1_end_z;
    end
  end

  // g_r: dir0 in 0..2, dir1 in 3..5, u in 6..8
  logic signed [P-1:0] g_r [S_DIR:S_MUL][9];
  always_ff @(posedge clk) begin
    if (en[S_DIR]) begin
      for (int k = 0; k < 3; k++) begin
        g_r[S_DIR][k]   <= P'(p_r[3+k]) - P'(p_r[k]);
        g_r[S_DIR][3+k] <= P'(p_r[9+k]) - P'(p_r[6+k]);
        g_r[S_DIR][6+k] <= P'(p_r[k]) - P'(p_r[6+k]);
      end
    end
  end
  for (genvar k = S_DIR + 1; k <= S_MUL; k++) begin : g_geo
    always_ff @(posedge clk) begin
      if (en[k]) begin
        g_r[k] <= g_r[k-1];
      end
    end
  end

  logic signed [PW-1:0] pr_r [15];
  always_ff @(posedge clk) begin
    if (en[S_PRD]) begin
      for (int k = 0; k < 3; k++) begin
        pr_r[k]    <= g_r[S_DIR][k]   * g_r[S_DIR][k];
        pr_r[3+k]  <= g_r[S_DIR][k]   * g_r[S_DIR][3+k];
        pr_r[6+k]  <= g_r[S_DIR][3+k] * g_r[S_DIR][3+k];
        pr_r[9+k]  <= g_r[S_DIR][k]   * g_r[S_DIR][6+k];
        pr_r[12+k] <= g_r[S_DIR][3+k] * g_r[S_DIR][6+k];
      end
    end
  end

  // dot_r: a, b, c, d, e
  logic signed [DW-1:0] dot_r [S_DOT:S_DET][NUM_DOT];
  always_ff @(posedge clk) begin
    if (en[S_DOT]) begin
      for (int k = 0; k < NUM_DOT; k++) begin
        dot_r[S_DOT][k] <= DW'(pr_r[3*k]) + DW'(pr_r[3*k+1]) + DW'(pr_r[3*k+2]);
      end
    end
  end
  for (genvar k = S_DOT + 1; k <= S_DET; k++) begin : g_dot
    always_ff @(posedge clk) begin
      if (en[k]) begin
        dot_r[k] <= dot_r[k-1];
      end
    end
  end

  // split the wide products: low half unsigned, high half signed
  logic signed [DW+H:0]       pl_r [NUM_WPROD];
  logic signed [2*DW-H-1:0]   ph_r [NUM_WPROD];
  logic signed [2*DW-1:0]     fp_r [NUM_WPROD];
  always_ff @(posedge clk) begin
    if (en[S_PP]) begin
      for (int k = 0; k < NUM_WPROD; k++) begin
        pl_r[k] <= dot_r[S_DOT][MX[k]] * $signed({1'b0, dot_r[S_DOT][MY[k]][H-1:0]});
        ph_r[k] <= dot_r[S_DOT][MX[k]] * $signed(dot_r[S_DOT][MY[k]][DW-1:H]);
      end
    end
    if (en[S_FP]) begin
      for (int k = 0; k < NUM_WPROD; k++) begin
        fp_r[k] <= ((2*DW)'(ph_r[k]) <<< H) + (2*DW)'(pl_r[k]);
      end
    end
  end

  logic signed [WW-1:0] det_r, snr_r, tnr_r;
  always_ff @(posedge clk) begin
    if (en[S_DET]) begin
      det_r <= WW'(fp_r[0]) - WW'(fp_r[1]);
      snr_r <= WW'(fp_r[2]) - WW'(fp_r[3]);
      tnr_r <= WW'(fp_r[4]) - WW'(fp_r[5]);
    end
  end

  logic signed [WW-1:0] sn_nxt, sd_nxt, tn_nxt, td_nxt;
  logic signed [DW:0]   ns_nxt;
  logic signed [DW-1:0] da, db, dc, dd, de;
  always_comb begin
    da = dot_r[S_DET][0];
    db = dot_r[S_DET][1];
    dc = dot_r[S_DET][2];
    dd = dot_r[S_DET][3];
    de = dot_r[S_DET][4];
    sd_nxt = det_r;
    ns_nxt = '0;
    if (det_r == '0) begin
      sn_nxt = '0;
      tn_nxt = WW'(de);
      td_nxt = WW'(dc);
    end else begin
      sn_nxt = snr_r;
      tn_nxt = tnr_r;
      td_nxt = det_r;
    end
    if (sn_nxt < 0) begin
      sn_nxt = '0;
      tn_nxt = WW'(de);
      td_nxt = WW'(dc);
    end else if (det_r < sn_nxt) begin
      sn_nxt = det_r;
      tn_nxt = WW'(de) + WW'(db);
      td_nxt = WW'(dc);
    end
    if (tn_nxt < 0 || td_nxt < tn_nxt) begin
      if (tn_nxt < 0) begin
        tn_nxt = '0;
        ns_nxt = -(DW+1)'(dd);
      end else begin
        tn_nxt = td_nxt;
        ns_nxt = (DW+1)'(db) - (DW+1)'(dd);
      end
      if (ns_nxt < 0) begin
        sn_nxt = '0;
      end else if (ns_nxt > (DW+1)'(da)) begin
        sn_nxt = WW'(1);
        sd_nxt = WW'(1);
      end else begin
        sn_nxt = WW'(ns_nxt);
        sd_nxt = WW'(da);
      end
    end
  end

  logic signed [WW-1:0] num_r [2];
  logic signed [WW-1:0] den_r [2];
  always_ff @(posedge clk) begin
    if (en[S_CLP]) begin
      num_r[0] <= sn_nxt;
      den_r[0] <= sd_nxt;
      num_r[1] <= tn_nxt;
      den_r[1] <= td_nxt;
    end
  end

  // restoring division, one quotient bit per stage; index 0 is s, 1 is t
  logic [WW-1:0] rem_r  [F+1][2];
  logic [WW-1:0] dvd_r  [F+1][2];
  logic [F-1:0]  q_r    [F+1][2];
  logic          zero_r [F+1][2];
  logic          one_r  [F+1][2];
  always_ff @(posedge clk) begin
    if (en[S_DIV]) begin
      for (int i = 0; i < 2; i++) begin
        zero_r[0][i] <= (den_r[i] <= 0) || (num_r[i] < 0);
        one_r[0][i]  <= (den_r[i] > 0) && (num_r[i] >= 0) && (num_r[i] >= den_r[i]);
        rem_r[0][i]  <= num_r[i];
        dvd_r[0][i]  <= den_r[i];
        q_r[0][i]    <= '0;
      end
    end
  end
  for (genvar j = 1; j <= F; j++) begin : g_div
    logic [WW-1:0] r2_nxt [2];
    logic          ge_nxt [2];
    always_comb begin
      for (int i = 0; i < 2; i++) begin
        r2_nxt[i] = {rem_r[j-1][i][WW-2:0], 1'b0};
        ge_nxt[i] = r2_nxt[i] >= dvd_r[j-1][i];
      end
    end
    always_ff @(posedge clk) begin
      if (en[S_DIV+j]) begin
        for (int i = 0; i < 2; i++) begin
          rem_r[j][i]  <= ge_nxt[i] ? r2_nxt[i] - dvd_r[j-1][i] : r2_nxt[i];
          q_r[j][i]    <= {q_r[j-1][i][F-2:0], ge_nxt[i]};
          dvd_r[j][i]  <= dvd_r[j-1][i];
          zero_r[j][i] <= zero_r[j-1][i];
          one_r[j][i]  <= one_r[j-1][i];
        end
      end
    end
  end

  logic [F:0] st_r [S_SEL:S_OUT][2];
  always_ff @(posedge clk) begin
    if (en[S_SEL]) begin
      for (int i = 0; i < 2; i++) begin
        if (zero_r[F][i]) begin
          st_r[S_SEL][i] <= '0;
        end else if (one_r[F][i]) begin
          st_r[S_SEL][i] <= (F+1)'(1) << F;
        end else begin
          st_r[S_SEL][i] <= {1'b0, q_r[F][i]};
        end
      end
    end
  end
  for (genvar k = S_SEL + 1; k <= S_OUT; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_r[k-1];
      end
    end
  end

  logic signed [MPW-1:0] ms_r [3];
  logic signed [MPW-1:0] mt_r [3];
  logic signed [P-1:0]   u_r  [3];
  logic signed [VW-1:0]  v_nxt [3];
  logic [VW-1:0]         mag_nxt [3];
  logic [MW-1:0]         m_r  [3];
  logic [2*MW-1:0]       sq_r [3];
  logic [DIST_W-1:0]     dist_r;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v_nxt[k]   = (VW'(u_r[k]) <<< F) + VW'(ms_r[k]) - VW'(mt_r[k]);
      mag_nxt[k] = v_nxt[k] < 0 ? VW'(-v_nxt[k]) : VW'(v_nxt[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      for (int k = 0; k < 3; k++) begin
        ms_r[k] <= $signed({1'b0, st_r[S_SEL][0]}) * g_r[S_SEL][k];
        mt_r[k] <= $signed({1'b0, st_r[S_SEL][1]}) * g_r[S_SEL][3+k];
        u_r[k]  <= g_r[S_SEL][6+k];
      end
    end
    if (en[S_VEC]) begin
      for (int k = 0; k < 3; k++) begin
        m_r[k] <= MW'(mag_nxt[k] >> (F - CUT_FRAC));
      end
    end
    if (en[S_SQR]) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= (2*MW)'(m_r[k]) * (2*MW)'(m_r[k]);
      end
    end
    if (en[S_OUT]) begin
      dist_r <= DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
    end
  end

  assign out_ch.valid        = vld_r[S_OUT];
  assign out_ch.dist_squared = dist_r;
  assign out_ch.s_param      = PARAM_W'(st_r[S_OUT][0]);
  assign out_ch.t_param      = PARAM_W'(st_r[S_OUT][1]);
endmodule

FILE: hdl/ssd_check.sv
// Port-level assertions for segment_segment_distance_sq, attached by bind.
// Depends on ssd_pkg.
module ssd_check import ssd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIST_W-1:0]  dist_squared,
  input logic [PARAM_W-1:0] s_param,
  input logic [PARAM_W-1:0] t_param
);
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(dist_squared) && $stable(s_param)
      && $stable(t_param))
    else $error("output word changed while stalled");
endmodule

bind segment_segment_distance_sq ssd_check u_ssd_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .dist_squared (out_ch.dist_squared),
  .s_param      (out_ch.s_param),
  .t_param      (out_ch.t_param)
);

FILE: tb/segment_segment_distance_sq_test.sv
// Testbench for the segment-pair squared distance pipeline: random and directed
// segment pairs checked against an in-bench closest-point predictor.
// Depends on ssd_pkg, ssd_if and segment_segment_distance_sq.
module segment_segment_distance_sq_test;
  import ssd_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = PARAM_FRAC_BITS_DEF;
  localparam int LATENCY = 14 + FB;
  localparam longint LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t [11:0] p;
  } seg_pair_t;
  typedef struct packed {
    logic [DIST_W-1:0]  dist_sq;
    logic [PARAM_W-1:0] s;
    logic [PARAM_W-1:0] t;
  } closest_t;

  logic clk, rst_n;
  ssd_in_if #(.COORD_BITS(CB)) in_ch ();
  ssd_out_if out_ch ();

  segment_segment_distance_sq #(.COORD_BITS(CB), .PARAM_FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  seg_pair_t pending_pairs[$];
  closest_t  expected_closest[$];
  int        errors = 0;
  int        checked = 0;
  longint    cycle = 0;
  bit        stim_done = 0;
  bit        no_idle = 0;
  bit        drain_pause = 0;
  int        hold_off = 0;
  int        parallel_seen = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [PARAM_W-1:0] frac_of(logic signed [127:0] num,
                                                  logic signed [127:0] den);
    if (den <= 0 || num < 0) return 0;
    if (num >= den) return 1 << FB;
    return (num <<< FB) / den;
  endfunction

  function automatic closest_t closest_points(seg_pair_t w);
    logic signed [63:0] d0[3], d1[3], u[3];
    logic signed [63:0] a, b, c, d, e, ns, v, m;
    logic signed [127:0] det, sn, sd, tn, td;
    logic [PARAM_W-1:0] s, t;
    logic [63:0] dist_acc;
    closest_t r;
    dist_acc = 0;
    for (int k = 0; k < 3; k++) begin
      d0[k] = 64'(w.p[3+k]) - 64'(w.p[k]);
      d1[k] = 64'(w.p[9+k]) - 64'(w.p[6+k]);
      u[k]  = 64'(w.p[k]) - 64'(w.p[6+k]);
    end
    a = d0[0]*d0[0] + d0[1]*d0[1] + d0[2]*d0[2];
    b = d0[0]*d1[0] + d0[1]*d1[1] + d0[2]*d1[2];
    c = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    d = d0[0]*u[0] + d0[1]*u[1] + d0[2]*u[2];
    e = d1[0]*u[0] + d1[1]*u[1] + d1[2]*u[2];
    det = 128'(a) * 128'(c) - 128'(b) * 128'(b);
    sd = det;
    td = det;
    if (det == 0) begin
      sn = 0; tn = e; td = c;
    end else begin
      sn = 128'(b) * 128'(e) - 128'(c) * 128'(d);
      tn = 128'(a) * 128'(e) - 128'(b) * 128'(d);
    end
    if (sn < 0) begin
      sn = 0; tn = e; td = c;
    end else if (det < sn) begin
      sn = det; tn = e + b; td = c;
    end
    if (tn < 0 || td < tn) begin
      if (tn < 0) begin
        tn = 0; ns = -d;
      end else begin
        tn = td; ns = b - d;
      end
      if (ns < 0) sn = 0;
      else if (ns > a) begin
        sn = 1; sd = 1;
      end else begin
        sn = ns; sd = a;
      end
    end
    s = frac_of(sn, sd);
    t = frac_of(tn, td);
    for (int k = 0; k < 3; k++) begin
      v = u[k] * (64'sd1 <<< FB) + $signed({47'd0, s}) * d0[k]
          - $signed({47'd0, t}) * d1[k];
      m = (v < 0 ? -v : v) >> (FB - CUT_FRAC);
      dist_acc += m * m;
    end
    r.dist_sq = dist_acc[DIST_W-1:0];
    r.s = s;
    r.t = t;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch word %0d %s: got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 64)) - 32;
      default: return coord_t'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic add_pair(seg_pair_t w);
    pending_pairs.push_back(w);
  endtask

  initial begin
    seg_pair_t w;
    int mode;
    coord_t lo, hi;
    lo = {1'b1, {(CB-1){1'b0}}};
    hi = {1'b0, {(CB-1){1'b1}}};
    for (int k = 0; k < 12; k++) w.p[k] = 0;
    add_pair(w);
    for (int k = 0; k < 12; k++) w.p[k] = lo;
    add_pair(w);
    for (int k = 0; k < 12; k++) w.p[k] = hi;
    add_pair(w);
    for (int k = 0; k < 12; k++) w.p[k] = (k % 6) < 3 ? lo : hi;
    add_pair(w);
    for (int k = 0; k < 12; k++) w.p[k] = (k % 6) < 3 ? hi : lo;
    add_pair(w);
    for (int k = 0; k < 12; k++) w.p[k] = k < 6 ? ((k % 6) < 3 ? lo : hi)
                                                : ((k % 6) < 3 ? hi : lo);
    add_pair(w);
    for (int k = 0; k < 12; k++) w.p[k] = coord_t'(k);
    add_pair(w);
    // parallel, collinear, degenerate and crossing shapes
    w.p = '{0, 0, 10, 0, 0, 0, 0, 5, 10, 0, 5, 0};
    add_pair(w);
    w.p = '{0, 0, 30, 0, 0, 20, 0, 0, 10, 0, 0, 0};
    add_pair(w);
    w.p = '{3, 3, 3, 3, 3, 3, 0, 0, 0, 0, 0, 0};
    add_pair(w);
    w.p = '{7, 8, 9, 7, 8, 9, 1, 2, 3, 1, 2, 3};
    add_pair(w);
    w.p = '{0, 10, 0, 0, -10, 0, 10, 0, 1, -10, 0, 1};
    add_pair(w);
    w.p = '{0, 0, 0, 5, 5, 5, 0, 0, 0, -5, -5, -5};
    add_pair(w);
    w.p = '{100, 0, 0, 200, 0, 0, 0, 0, 0, 1, 0, 0};
    add_pair(w);
    w.p = '{0, 0, 0, 0, 0, 0, 9, 9, 9, 1, 1, 1};
    add_pair(w);
    w.p = '{hi, hi, hi, lo, lo, lo, lo, hi, lo, hi, lo, hi};
    add_pair(w);
    for (int n = 0; n < 1200; n++) begin
      mode = $urandom_range(0, 2);
      for (int k = 0; k < 12; k++) w.p[k] = rand_coord(mode);
      if ($urandom_range(0, 9) == 0) begin
        // make the second segment parallel to the first
        for (int k = 0; k < 3; k++) w.p[9+k] = w.p[6+k] + (w.p[3+k] - w.p[k]);
      end
      if ($urandom_range(0, 19) == 0)
        for (int k = 0; k < 3; k++) w.p[3+k] = w.p[k];
      add_pair(w);
    end
  end

  initial begin
    rst_n = 0;
    in_ch.valid = 0;
    out_ch.ready = 0;
    {in_ch.seg0_start_x, in_ch.seg0_start_y, in_ch.seg0_start_z,
     in_ch.seg0_end_x, in_ch.seg0_end_y, in_ch.seg0_end_z,
     in_ch.seg1_start_x, in_ch.seg1_start_y, in_ch.seg1_start_z,
     in_ch.seg1_end_x, in_ch.seg1_end_y, in_ch.seg1_end_z} = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    no_idle <= (cycle > 700 && cycle < 1000);
    if (cycle == 200) hold_off <= 400;
    else if (hold_off > 0) hold_off <= hold_off - 1;
    if (cycle == 1100) drain_pause <= 1;
    else if (drain_pause && expected_closest.size() == 0 && !in_ch.valid) drain_pause <= 0;
  end

  // driver
  always @(posedge clk) begin
    seg_pair_t w;
    bit fire;
    if (rst_n) begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        w = pending_pairs.pop_front();
        expected_closest.push_back(closest_points(w));
      end
      if ((fire || !in_ch.valid) && pending_pairs.size() > 0 && !drain_pause &&
          (no_idle || $urandom_range(0, 99) >= 14)) begin
        w = pending_pairs[0];
        {in_ch.seg0_start_x, in_ch.seg0_start_y, in_ch.seg0_start_z,
         in_ch.seg0_end_x, in_ch.seg0_end_y, in_ch.seg0_end_z,
         in_ch.seg1_start_x, in_ch.seg1_start_y, in_ch.seg1_start_z,
         in_ch.seg1_end_x, in_ch.seg1_end_y, in_ch.seg1_end_z} <=
          {w.p[0], w.p[1], w.p[2], w.p[3], w.p[4], w.p[5],
           w.p[6], w.p[7], w.p[8], w.p[9], w.p[10], w.p[11]};
        in_ch.valid <= 1;
      end else if (fire || !in_ch.valid) begin
        in_ch.valid <= 0;
        if (pending_pairs.size() == 0) stim_done <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    closest_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_closest.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_closest.pop_front();
          if (out_ch.dist_squared !== want.dist_sq)
            report_mismatch("dist_squared", out_ch.dist_squared, want.dist_sq);
          if (out_ch.s_param !== want.s) report_mismatch("s_param", out_ch.s_param, want.s);
          if (out_ch.t_param !== want.t) report_mismatch("t_param", out_ch.t_param, want.t);
          if (want.s == 0 && want.t == 0) parallel_seen++;
        end
        checked++;
      end
      out_ch.ready <= hold_off == 0 && (no_idle || $urandom_range(0, 99) >= 14);
    end
  end

  initial begin
    wait (stim_done && expected_closest.size() == 0 && !in_ch.valid);
    repeat (LATENCY * 3) @(posedge clk);
    $display("checked %0d result words under random stalls, a long output hold-off", checked);
    $display("and a full drain pause; %0d had both parameters clamped to zero", parallel_seen);
    if (errors == 0 && expected_closest.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    wait (cycle >= LIMIT);
    $display("timeout after %0d cycles", cycle);
    $display("simulation failed");
    $finish;
  end
endmodule

FILE: sim.f
hdl/ssd_pkg.sv
hdl/ssd_if.sv
hdl/segment_segment_distance_sq.sv
hdl/ssd_check.sv
tb/segment_segment_distance_sq_test.sv
